>>> sv/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 engine package
// Shared types, round constants and initial hash values for the SHA-256
// engine and its compression core.
// ----------------------------------------------------------------------------
package sha_pkg;

  // One input word of the message stream.
  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
  } in_word_t;

  // One digest word on the result channel.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_result;
  } out_word_t;

  // Commands from the sequencer to the compression core.
  typedef struct packed {
    logic start;
    logic init_hash;
  } core_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_PAD,
    ST_LEN,
    ST_LOAD,
    ST_COMPRESS,
    ST_DIGEST
  } state_e;

  localparam int unsigned NumRounds = 64;
  localparam int unsigned RoundW    = 6;

  localparam logic [7:0][31:0] HashInit = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] round_const(input logic [RoundW-1:0] t);
    logic [31:0] k;
    case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

>>> sv/sha_core.sv
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Holds the hash state and runs one compression round per cycle on a
// loaded 16-word block, then folds the working variables into the hash.
// ----------------------------------------------------------------------------
module sha_core import sha_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  core_ctrl_t       ctrl_i,
  input  logic [15:0][31:0] block_i,
  output logic             done_o,
  output logic [7:0][31:0] hash_o
);

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  logic [7:0][31:0]  hash_q;
  logic [7:0][31:0]  v_q;
  logic [15:0][31:0] w_q;
  logic [RoundW-1:0] cnt_q;
  logic              busy_q;
  logic              fin_q;

  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;

  // The schedule is a shift line: w_q[0] is the word of the current round.
  assign w_new = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];

  assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + round_const(cnt_q) + w_q[0];
  assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
      hash_q <= HashInit;
    end else begin
      fin_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == RoundW'(NumRounds - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
      if (ctrl_i.init_hash) begin
        hash_q <= HashInit;
      end else if (fin_q) begin
        for (int i = 0; i < 8; i++) begin
          hash_q[i] <= hash_q[i] + v_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      v_q <= hash_q;
      w_q <= block_i;
    end else if (busy_q) begin
      v_q <= {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
      w_q <= {w_new, w_q[15:1]};
    end
  end

  assign done_o = fin_q;
  assign hash_o = hash_q;

endmodule

>>> sv/sha256_hash_engine_top.sv
// ----------------------------------------------------------------------------
// SHA-256 hash engine
// Packs message words into 64-byte blocks, pads the final block and
// streams out the eight digest words of each message.
// ----------------------------------------------------------------------------
// Usage: message words enter on the in channel (valid/ready) as big-endian
// 32-bit words with a byte count. Only the final word of a message may carry
// fewer than four bytes; a count above four is taken as four, and an empty
// final word only closes the message. The engine takes one word at a time.
// A word that does not complete a block is taken in the idle state and
// written into the block by an insert pass. A word that completes a block
// also needs a compression (64 rounds in the shared round unit, one load
// and one hash update) and a second insert pass for the leftover bytes.
// The final word adds one padding pass and one or two compressions before
// the first digest word. The digest then leaves on the out channel as eight
// words, most significant first, the eighth one flagged last. While the
// receiver stalls, the word on offer is held and no new input is taken.
// After the eighth word is taken the hash state returns to the initial
// values. Reset loads the initial values and clears the byte and block
// counts; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sha256_hash_engine_top import sha_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  state_e st_q, st_d;
  state_e ret_q, ret_d;

  logic [15:0][31:0] win_q, win_d;
  logic [5:0]        fill_q, fill_d;
  logic [54:0]       blk_q, blk_d;
  logic [31:0]       data_q, data_d;
  logic [2:0]        nb_q, nb_d;
  logic              last_q, last_d;
  logic [2:0]        idx_q, idx_d;

  core_ctrl_t        ctrl;
  logic              core_done;
  logic [7:0][31:0]  hash;

  logic [6:0]  space;
  logic [6:0]  nwr;
  logic [6:0]  sum;
  logic [63:0] bit_len;

  // Bytes of the held word that still fit in the current block.
  assign space   = 7'd64 - {1'b0, fill_q};
  assign nwr     = ({4'b0, nb_q} < space) ? {4'b0, nb_q} : space;
  assign sum     = {1'b0, fill_q} + nwr;
  // Bit length is blocks * 512 + bytes * 8; the fields simply concatenate.
  assign bit_len = {blk_q, fill_q, 3'b000};

  sha_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .block_i (win_q),
    .done_o  (core_done),
    .hash_o  (hash)
  );

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (in_valid_i) st_d = ST_INSERT;
      end
      ST_INSERT: begin
        if (sum[6]) st_d = ST_LOAD;
        else if (last_q) st_d = ST_PAD;
        else st_d = ST_IDLE;
      end
      ST_PAD:      st_d = ST_LOAD;
      ST_LEN:      st_d = ST_LOAD;
      ST_LOAD:     st_d = ST_COMPRESS;
      ST_COMPRESS: begin
        if (core_done) st_d = ret_q;
      end
      ST_DIGEST: begin
        if (out_ready_i && idx_q == 3'd7) st_d = ST_IDLE;
      end
      default:     st_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    logic [6:0] pos;
    win_d          = win_q;
    fill_d         = fill_q;
    blk_d          = blk_q;
    data_d         = data_q;
    nb_d           = nb_q;
    last_d         = last_q;
    idx_d          = idx_q;
    ret_d          = ret_q;
    ctrl.start     = 1'b0;
    ctrl.init_hash = 1'b0;
    in_ready_o     = 1'b0;
    out_valid_o    = 1'b0;
    pos            = '0;
    case (st_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        data_d     = in_word_i.data_word;
        nb_d       = in_word_i.valid_bytes[2] ? 3'd4 : in_word_i.valid_bytes;
        last_d     = in_word_i.last_word;
      end
      ST_INSERT: begin
        for (int k = 0; k < 4; k++) begin
          pos = {1'b0, fill_q} + 7'(k);
          if (3'(k) < nb_q && !pos[6]) begin
            win_d[pos[5:2]][{~pos[1:0], 3'b000} +: 8] = data_q[31 - 8*k -: 8];
          end
        end
        if (sum[6]) begin
          // Block is full: keep the leftover bytes for after the compression.
          fill_d = '0;
          blk_d  = blk_q + 1'b1;
          data_d = data_q << {nwr[2:0], 3'b000};
          nb_d   = nb_q - nwr[2:0];
          ret_d  = ST_INSERT;
        end else begin
          fill_d = sum[5:0];
        end
      end
      ST_PAD: begin
        for (int p = 0; p < 64; p++) begin
          if (6'(p) == fill_q) begin
            win_d[p[5:2]][{~p[1:0], 3'b000} +: 8] = PadByte;
          end else if (6'(p) > fill_q) begin
            win_d[p[5:2]][{~p[1:0], 3'b000} +: 8] = 8'h00;
          end
        end
        // With fewer than nine bytes left the length goes to an extra block.
        if (fill_q > 6'd55) begin
          ret_d = ST_LEN;
        end else begin
          win_d[14] = bit_len[63:32];
          win_d[15] = bit_len[31:0];
          ret_d     = ST_DIGEST;
        end
      end
      ST_LEN: begin
        win_d     = '0;
        win_d[14] = bit_len[63:32];
        win_d[15] = bit_len[31:0];
        ret_d     = ST_DIGEST;
      end
      ST_LOAD: begin
        ctrl.start = 1'b1;
      end
      ST_COMPRESS: begin
      end
      ST_DIGEST: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == 3'd7) begin
            ctrl.init_hash = 1'b1;
            fill_d         = '0;
            blk_d          = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_word_o.digest_word = hash[idx_q];
  assign out_word_o.word_index  = idx_q;
  assign out_word_o.last_result = (idx_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      ret_q  <= ST_IDLE;
      fill_q <= '0;
      blk_q  <= '0;
      idx_q  <= '0;
    end else begin
      st_q   <= st_d;
      ret_q  <= ret_d;
      fill_q <= fill_d;
      blk_q  <= blk_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q  <= win_d;
    data_q <= data_d;
    nb_q   <= nb_d;
    last_q <= last_d;
  end

endmodule
